/* rtl/rlt_pkg.sv */
// shared types and constants for the rtp loss resend tracker
`default_nettype none
package rlt_pkg;

   // payload type codes with the marker bit cleared
   localparam logic [6:0] KIND_DATA   = 7'h60;
   localparam logic [6:0] KIND_RESENT = 7'h56;

   // configuration register indexes and the expiry age reset value
   localparam logic [7:0]  CSR_EXPIRY_AGE = 8'd0;
   localparam logic [7:0]  CSR_CONTROL_EN = 8'd1;
   localparam logic [15:0] EXPIRY_RESET   = 16'd500;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_DATA,
      OP_RESENT
   } op_type;

   // classified packet handed from front to back
   typedef struct packed {
      op_type      op;
      logic        track;
      logic        req;
      logic [15:0] first_seq;
      logic [15:0] count;
      logic [15:0] seq;
      logic [31:0] now;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REFRESH,
      ST_INSERT,
      ST_MATCH,
      ST_EXPIRE,
      ST_DONE
   } bck_state_type;

endpackage
`default_nettype wire

/* rtl/rlt_front.sv */
// front end: accepts packet headers, detects gaps and tracks the last sequence
`default_nettype none
module rlt_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [6:0]            req_kind,
   input  wire  [15:0]           req_sequence_req,
   input  wire  [31:0]           req_now_ms,
   input  wire                   control_enabled,
   input  rlt_pkg::q_status_type q_status,
   output logic                  push,
   output rlt_pkg::cmd_type      push_cmd
);

   logic        seen_any_ff, seen_any_in;
   logic [15:0] last_seq_ff, last_seq_in;
   logic [15:0] expected;
   logic [15:0] diff;
   logic        gap;
   logic        is_data;
   logic        is_resent;

   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   // classify the packet
   always_comb begin
      is_data   = (req_kind == rlt_pkg::KIND_DATA);
      is_resent = (req_kind == rlt_pkg::KIND_RESENT);
      expected  = last_seq_ff + 16'd1;
      diff      = req_sequence_req - expected;
      gap       = is_data && seen_any_ff && (req_sequence_req != expected) && control_enabled;

      push_cmd.op        = is_data ? rlt_pkg::OP_DATA :
                           (is_resent ? rlt_pkg::OP_RESENT : rlt_pkg::OP_NONE);
      push_cmd.req       = gap;
      push_cmd.track     = gap && !diff[15];
      push_cmd.first_seq = gap ? expected : 16'd0;
      push_cmd.count     = gap ? diff : 16'd0;
      push_cmd.seq       = req_sequence_req;
      push_cmd.now       = req_now_ms;

      seen_any_in = seen_any_ff;
      last_seq_in = last_seq_ff;
      if (push && is_data) begin
         seen_any_in = 1'b1;
         last_seq_in = req_sequence_req;
      end
   end

   // stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_any_ff <= 1'b0;
         last_seq_ff <= 16'd0;
      end else begin
         seen_any_ff <= seen_any_in;
         last_seq_ff <= last_seq_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/rlt_queue.sv */
// two-entry command queue between front and back
`default_nettype none
module rlt_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  rlt_pkg::cmd_type      push_cmd,
   input  wire                   pop,
   output rlt_pkg::cmd_type      head_cmd,
   output rlt_pkg::q_status_type status
);

   rlt_pkg::cmd_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd         = slot_ff[rd_ptr_ff];
   assign status.full      = (fill_ff == 2'd2);
   assign status.not_empty = (fill_ff != 2'd0);

endmodule
`default_nettype wire

/* rtl/rlt_back.sv */
// back end: outstanding table scans for refresh, insertion, match and expiry
`default_nettype none
module rlt_back #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire  [15:0]           expiry_age_ms,
   input  rlt_pkg::q_status_type q_status,
   input  rlt_pkg::cmd_type      head_cmd,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic                  rsp_request_valid,
   output logic [15:0]           rsp_request_first_seq,
   output logic signed [15:0]    rsp_request_count,
   output logic                  rsp_resend_matched,
   output logic                  rsp_resend_unexpected,
   output logic [6:0]            rsp_expired_count,
   output logic                  rsp_table_overflow
);

   localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNTW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNTW-1:0] DEPTH_C = CNTW'(TABLE_DEPTH);

   // entry memories, one write and one registered read port each
   logic [15:0] seq_mem  [TABLE_DEPTH];
   logic [31:0] time_mem [TABLE_DEPTH];

   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;

   rlt_pkg::bck_state_type state_ff, state_in;
   rlt_pkg::cmd_type       cmd_ff, cmd_in;

   logic [CNTW-1:0] iss_ff, iss_in;
   logic            rd_live_ff, rd_live_in;
   logic [IDXW-1:0] rd_idx_ff;
   logic [15:0]     rd_seq_ff;
   logic [31:0]     rd_time_ff;

   logic [15:0]     k_ff, k_in;
   logic            found_ff, found_in;
   logic            free_ok_ff, free_ok_in;
   logic [IDXW-1:0] free_idx_ff, free_idx_in;
   logic            overflow_ff, overflow_in;
   logic            matched_ff, matched_in;
   logic [CNTW-1:0] exp_cnt_ff, exp_cnt_in;

   logic            out_valid_ff, out_valid_in;
   logic            out_req_ff;
   logic [15:0]     out_first_ff;
   logic [15:0]     out_count_ff;
   logic            out_matched_ff;
   logic            out_unexp_ff;
   logic [CNTW-1:0] out_exp_ff;
   logic            out_overflow_ff;
   logic            out_load;

   logic            in_scan;
   logic            issuing;
   logic            rd_en;
   logic            scan_done;
   logic            cur_valid;
   logic [15:0]     cur_seq;
   logic [15:0]     offs;
   logic [31:0]     age;

   logic            tw_en;
   logic [IDXW-1:0] tw_idx;
   logic            sw_en;
   logic [31:0]     exp_wide;

   // scan pipeline helpers
   always_comb begin
      in_scan   = (state_ff == rlt_pkg::ST_REFRESH) || (state_ff == rlt_pkg::ST_INSERT) ||
                  (state_ff == rlt_pkg::ST_MATCH) || (state_ff == rlt_pkg::ST_EXPIRE);
      issuing   = (iss_ff < DEPTH_C);
      rd_en     = in_scan && issuing;
      scan_done = !issuing && !rd_live_ff;
      cur_valid = rd_live_ff && valid_ff[rd_idx_ff];
      cur_seq   = cmd_ff.first_seq + k_ff;
      offs      = rd_seq_ff - cmd_ff.first_seq;
      age       = cmd_ff.now - rd_time_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      iss_in       = in_scan ? (iss_ff + CNTW'(issuing)) : iss_ff;
      rd_live_in   = rd_en;
      k_in         = k_ff;
      found_in     = found_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      overflow_in  = overflow_ff;
      matched_in   = matched_ff;
      exp_cnt_in   = exp_cnt_ff;
      valid_in     = valid_ff;
      tw_en        = 1'b0;
      tw_idx       = rd_idx_ff;
      sw_en        = 1'b0;
      pop          = 1'b0;
      out_load     = 1'b0;

      case (state_ff)
         rlt_pkg::ST_IDLE: begin
            if (q_status.not_empty) begin
               pop         = 1'b1;
               cmd_in      = head_cmd;
               iss_in      = '0;
               rd_live_in  = 1'b0;
               k_in        = 16'd0;
               found_in    = 1'b0;
               free_ok_in  = 1'b0;
               overflow_in = 1'b0;
               matched_in  = 1'b0;
               exp_cnt_in  = '0;
               case (head_cmd.op)
                  rlt_pkg::OP_DATA:   state_in = head_cmd.track ? rlt_pkg::ST_REFRESH :
                                                                  rlt_pkg::ST_EXPIRE;
                  rlt_pkg::OP_RESENT: state_in = rlt_pkg::ST_MATCH;
                  default:            state_in = rlt_pkg::ST_DONE;
               endcase
            end
         end
         rlt_pkg::ST_REFRESH: begin
            // restamp entries already inside the gap
            if (cur_valid && (offs < cmd_ff.count)) begin
               tw_en = 1'b1;
            end
            if (scan_done) begin
               state_in   = rlt_pkg::ST_INSERT;
               iss_in     = '0;
               rd_live_in = 1'b0;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
            end
         end
         rlt_pkg::ST_INSERT: begin
            // look for the current sequence and the lowest free slot
            if (cur_valid && (rd_seq_ff == cur_seq)) begin
               found_in = 1'b1;
            end
            if (rd_live_ff && !valid_ff[rd_idx_ff] && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_idx_in = rd_idx_ff;
            end
            if (scan_done) begin
               iss_in     = '0;
               rd_live_in = 1'b0;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
               if (found_ff || free_ok_ff) begin
                  if (!found_ff) begin
                     tw_en                 = 1'b1;
                     sw_en                 = 1'b1;
                     tw_idx                = free_idx_ff;
                     valid_in[free_idx_ff] = 1'b1;
                  end
                  k_in = k_ff + 16'd1;
                  if ((k_ff + 16'd1) == cmd_ff.count) begin
                     state_in = rlt_pkg::ST_EXPIRE;
                  end
               end else begin
                  overflow_in = 1'b1;
                  state_in    = rlt_pkg::ST_EXPIRE;
               end
            end
         end
         rlt_pkg::ST_MATCH: begin
            if (cur_valid && (rd_seq_ff == cmd_ff.seq)) begin
               valid_in[rd_idx_ff] = 1'b0;
               matched_in          = 1'b1;
            end
            if (scan_done) begin
               state_in   = rlt_pkg::ST_EXPIRE;
               iss_in     = '0;
               rd_live_in = 1'b0;
            end
         end
         rlt_pkg::ST_EXPIRE: begin
            if (cur_valid && (age > {16'd0, expiry_age_ms})) begin
               valid_in[rd_idx_ff] = 1'b0;
               exp_cnt_in          = exp_cnt_ff + CNTW'(1);
            end
            if (scan_done) begin
               state_in = rlt_pkg::ST_DONE;
            end
         end
         rlt_pkg::ST_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = rlt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rlt_pkg::ST_IDLE;
         end
      endcase

      out_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlt_pkg::ST_IDLE;
         valid_ff     <= '0;
         iss_ff       <= '0;
         rd_live_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         iss_ff       <= iss_in;
         rd_live_ff   <= rd_live_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      k_ff        <= k_in;
      found_ff    <= found_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      overflow_ff <= overflow_in;
      matched_ff  <= matched_in;
      exp_cnt_ff  <= exp_cnt_in;
      rd_idx_ff   <= iss_ff[IDXW-1:0];
   end

   // entry memories
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_seq_ff  <= seq_mem[iss_ff[IDXW-1:0]];
         rd_time_ff <= time_mem[iss_ff[IDXW-1:0]];
      end
      if (tw_en) begin
         time_mem[tw_idx] <= cmd_ff.now;
      end
      if (sw_en) begin
         seq_mem[tw_idx] <= cur_seq;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_req_ff      <= cmd_ff.req;
         out_first_ff    <= cmd_ff.first_seq;
         out_count_ff    <= cmd_ff.count;
         out_matched_ff  <= matched_ff;
         out_unexp_ff    <= (cmd_ff.op == rlt_pkg::OP_RESENT) && !matched_ff;
         out_exp_ff      <= exp_cnt_ff;
         out_overflow_ff <= overflow_ff;
      end
   end

   assign exp_wide              = 32'(out_exp_ff);
   assign rsp_valid             = out_valid_ff;
   assign rsp_request_valid     = out_req_ff;
   assign rsp_request_first_seq = out_first_ff;
   assign rsp_request_count     = $signed(out_count_ff);
   assign rsp_resend_matched    = out_matched_ff;
   assign rsp_resend_unexpected = out_unexp_ff;
   assign rsp_expired_count     = exp_wide[6:0];
   assign rsp_table_overflow    = out_overflow_ff;

   // checks
   a_exp_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != rlt_pkg::ST_IDLE) |-> (exp_cnt_ff <= DEPTH_C))
      else $error("expiry count beyond table depth");

   a_overflow_op: assert property (@(posedge clock) disable iff (reset)
      (state_ff != rlt_pkg::ST_IDLE) && overflow_ff |-> cmd_ff.track)
      else $error("overflow without a tracked gap");

   a_match_op: assert property (@(posedge clock) disable iff (reset)
      (state_ff != rlt_pkg::ST_IDLE) && matched_ff |-> (cmd_ff.op == rlt_pkg::OP_RESENT))
      else $error("match on a non-resent packet");

   a_insert_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rlt_pkg::ST_INSERT) |-> (k_ff < cmd_ff.count))
      else $error("insertion past the end of the gap");

endmodule
`default_nettype wire

/* rtl/rtp_loss_resend_tracker.sv */
// top level of the rtp loss resend tracker
`default_nettype none
// Tracks sequence gaps of a received audio packet stream and the outstanding
// resend requests. The front end takes a header per transfer, spots gaps and
// queues the packet; the back end works each packet through the outstanding
// table over its entry memories, one entry a cycle. An ignored kind goes
// straight to the result, a data packet without a tracked gap takes one expiry
// scan, a resent packet a match scan and then an expiry scan, and a tracked gap
// a refresh scan, one insertion scan for each missed sequence examined (at most
// TABLE_DEPTH+1 of them) and then an expiry scan.
// The two-entry queue lets up to two further headers be taken meanwhile.
module rtp_loss_resend_tracker #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [6:0]         req_kind,
   input  wire  [15:0]        req_sequence_req,
   input  wire  [31:0]        req_now_ms,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic               rsp_request_valid,
   output logic [15:0]        rsp_request_first_seq,
   output logic signed [15:0] rsp_request_count,
   output logic               rsp_resend_matched,
   output logic               rsp_resend_unexpected,
   output logic [6:0]         rsp_expired_count,
   output logic               rsp_table_overflow,
   input  wire                csr_wr_en,
   input  wire  [7:0]         csr_index,
   input  wire  [15:0]        csr_wdata
);

   logic [15:0] expiry_ff;
   logic        control_ff;

   rlt_pkg::q_status_type q_status;
   rlt_pkg::cmd_type      push_cmd;
   rlt_pkg::cmd_type      head_cmd;
   logic                  push;
   logic                  pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         expiry_ff  <= rlt_pkg::EXPIRY_RESET;
         control_ff <= 1'b1;
      end else if (csr_wr_en) begin
         if (csr_index == rlt_pkg::CSR_EXPIRY_AGE) begin
            expiry_ff <= csr_wdata;
         end else if (csr_index == rlt_pkg::CSR_CONTROL_EN) begin
            control_ff <= csr_wdata[0];
         end
      end
   end

   rlt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_sequence_req (req_sequence_req),
      .req_now_ms       (req_now_ms),
      .control_enabled  (control_ff),
      .q_status         (q_status),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   rlt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   rlt_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .expiry_age_ms         (expiry_ff),
      .q_status              (q_status),
      .head_cmd              (head_cmd),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_request_valid     (rsp_request_valid),
      .rsp_request_first_seq (rsp_request_first_seq),
      .rsp_request_count     (rsp_request_count),
      .rsp_resend_matched    (rsp_resend_matched),
      .rsp_resend_unexpected (rsp_resend_unexpected),
      .rsp_expired_count     (rsp_expired_count),
      .rsp_table_overflow    (rsp_table_overflow)
   );

endmodule
`default_nettype wire
